// File: hdl/i2cbm_pkg.sv
// types, codes and the phase pin table for the byte-level i2c master
// no dependencies
package i2cbm_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int DATA_PHASES = 2 * BYTE_BITS;
    localparam int PH_W        = 5;

    localparam logic [PH_W-1:0] LAST_START = PH_W'(1);
    localparam logic [PH_W-1:0] LAST_STOP  = PH_W'(2);
    localparam logic [PH_W-1:0] LAST_BYTE  = PH_W'(DATA_PHASES + 1);
    localparam logic [PH_W-1:0] DATA_END   = PH_W'(DATA_PHASES);

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } op_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic oe;
    } pins_t;

    typedef struct packed {
        op_t                 op;
        logic [PH_W-1:0]     ph;
        logic [15:0]         tc;
        logic [BYTE_BITS-1:0] sb;
        pins_t               pins;
        logic                ack_seen;
        logic                ack_send;
        logic [BYTE_BITS-1:0] rx_hold;
    } state_t;

    typedef struct packed {
        logic                 ack_in;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 done_res;
        logic                 busy_res;
        logic                 sda_oe;
        logic                 sda_out;
        logic                 scl;
    } res_t;

    function automatic pins_t set_pins(input logic c, input logic d, input logic e);
        pins_t p;
        p.scl = c;
        p.sda = e ? d : 1'b1;
        p.oe  = e;
        return p;
    endfunction

    // pin levels at the first tick of a phase
    function automatic pins_t phase_pins(input op_t op, input logic [PH_W-1:0] ph,
                                         input logic [BYTE_BITS-1:0] sb, input logic as);
        pins_t p;
        p = set_pins(1'b1, 1'b1, 1'b0);
        unique case (op)
            OP_START: p = set_pins(1'b1, (ph == '0), 1'b1);
            OP_STOP:  p = set_pins((ph != '0), (ph == LAST_STOP), 1'b1);
            OP_WRITE:
            begin
                if (ph < DATA_END)
                    p = set_pins(ph[0], sb[BYTE_BITS-1], 1'b1);
                else
                    p = set_pins(ph[0], 1'b1, 1'b0);
            end
            OP_READ:
            begin
                if (ph < DATA_END)
                    p = set_pins(ph[0], 1'b1, 1'b0);
                else
                    p = set_pins(ph[0], as, 1'b1);
            end
            default: p = set_pins(1'b1, 1'b1, 1'b0);
        endcase
        return p;
    endfunction

endpackage

// File: hdl/i2cbm_step.sv
// next-state and result logic for one tick of the i2c byte sequencer
// depends on i2cbm_pkg
module i2cbm_step
    import i2cbm_pkg::*;
(
    input  state_t      cur,
    input  logic [2:0]  cmd,
    input  logic [7:0]  wr_byte,
    input  logic        ack_out,
    input  logic        sda_in,
    input  logic [15:0] half_period,
    output state_t      nxt,
    output res_t        res
);

    logic        start;
    op_t         cmd_op;
    state_t      s0;
    logic [15:0] hp_m1;
    logic [PH_W-1:0] last_ph;
    logic        busy;
    logic        done;

    always_comb
    begin
        cmd_op = OP_IDLE;
        unique case (cmd)
            CMD_START: cmd_op = OP_START;
            CMD_STOP:  cmd_op = OP_STOP;
            CMD_WRITE: cmd_op = OP_WRITE;
            CMD_READ:  cmd_op = OP_READ;
            default:   cmd_op = OP_IDLE;
        endcase
    end

    assign start = (cur.op == OP_IDLE) && (cmd_op != OP_IDLE);
    assign hp_m1 = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;

    // command pickup
    always_comb
    begin
        s0 = cur;
        if (start)
        begin
            s0.op = cmd_op;
            s0.ph = '0;
            s0.tc = '0;
            s0.sb = (cmd_op == OP_WRITE) ? wr_byte : '0;
            if (cmd_op == OP_READ)
                s0.ack_send = ack_out;
            s0.pins = phase_pins(cmd_op, '0, s0.sb, s0.ack_send);
        end
    end

    always_comb
    begin
        unique case (s0.op)
            OP_START: last_ph = LAST_START;
            OP_STOP:  last_ph = LAST_STOP;
            default:  last_ph = LAST_BYTE;
        endcase
    end

    // phase timing, bit shifting, ack capture and completion
    always_comb
    begin
        nxt  = s0;
        busy = 1'b0;
        done = 1'b0;
        if (s0.op != OP_IDLE)
        begin
            busy = 1'b1;
            if (s0.tc >= hp_m1)
            begin
                if (s0.op == OP_WRITE)
                begin
                    if (s0.ph < DATA_END && s0.ph[0])
                        nxt.sb = {s0.sb[BYTE_BITS-2:0], 1'b0};
                    else if (s0.ph == LAST_BYTE)
                        nxt.ack_seen = sda_in;
                end
                else if (s0.op == OP_READ)
                begin
                    if (s0.ph < DATA_END && s0.ph[0])
                        nxt.sb = {s0.sb[BYTE_BITS-2:0], sda_in};
                end
                nxt.tc = '0;
                if (s0.ph >= last_ph)
                begin
                    if (s0.op == OP_READ)
                        nxt.rx_hold = nxt.sb;
                    nxt.op = OP_IDLE;
                    nxt.ph = '0;
                    done   = 1'b1;
                end
                else
                begin
                    nxt.ph   = s0.ph + PH_W'(1);
                    nxt.pins = phase_pins(s0.op, s0.ph + PH_W'(1), nxt.sb, s0.ack_send);
                end
            end
            else
            begin
                nxt.tc = s0.tc + 16'd1;
            end
        end
    end

    always_comb
    begin
        res.scl      = s0.pins.scl;
        res.sda_out  = s0.pins.sda;
        res.sda_oe   = s0.pins.oe;
        res.busy_res = busy;
        res.done_res = done;
        res.rx_byte  = nxt.rx_hold;
        res.ack_in   = nxt.ack_seen;
    end

endmodule

// File: hdl/i2c_byte_master.sv
// i2c byte master: one request per tick, one result per request, registered output
// depends on i2cbm_pkg and i2cbm_step
//
// Byte-level I2C master sequencer. Every input request is one bus tick and yields
// exactly one result carrying the SCL/SDA pin levels, busy, done, the last read byte
// and the last write ack. While idle a start, stop, write or read command begins a
// fixed sequence of SCL phases of half_period ticks each (zero counts as one); SDA is
// sampled on the last tick of each SCL-high data or write-ack phase, and commands seen
// while busy are dropped. Throughput is one request per clock: the tick logic sits
// between the sequencer state registers and a single output register, so a new request
// is taken whenever the output register is empty or being drained in the same cycle.
module i2c_byte_master
    import i2cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // half_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // cmd[2:0], wr_byte[10:3], ack_out[11], sda_in[12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // scl, sda_out, sda_oe, busy_res, done_res,
                                         // rx_byte[12:5], ack_in[13]
);

    logic [15:0] half_period_reg;
    state_t      state_reg;
    state_t      state_next;
    res_t        res_next;
    res_t        res_reg;
    logic        m_valid_reg;
    logic        accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    i2cbm_step u_step (
        .cur         (state_reg),
        .cmd         (s_axis_tdata[2:0]),
        .wr_byte     (s_axis_tdata[10:3]),
        .ack_out     (s_axis_tdata[11]),
        .sda_in      (s_axis_tdata[12]),
        .half_period (half_period_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op       <= OP_IDLE;
            state_reg.ph       <= '0;
            state_reg.tc       <= '0;
            state_reg.sb       <= '0;
            state_reg.pins     <= set_pins(1'b1, 1'b1, 1'b0);
            state_reg.ack_seen <= 1'b0;
            state_reg.ack_send <= 1'b0;
            state_reg.rx_hold  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, res_reg};

endmodule
